// ----- sv/dxt_pkg.sv -----
// Shared types and constants for the DXT block decoder.
package dxt_pkg;

    // Block format codes held in the format register.
    typedef enum logic [1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2
    } t_fmt;

    localparam logic [1:0] LAST_ROW     = 2'd3;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Per-block palette: four colors, the DXT1 three-color flag and the
    // eight-entry interpolated alpha table.
    typedef struct packed {
        logic [3:0][7:0] red;
        logic [3:0][7:0] green;
        logic [3:0][7:0] blue;
        logic            three_color;
        logic [7:0][7:0] alpha;
    } t_pal;

endpackage

// ----- sv/dxt_cfg_if.sv -----
// Configuration write channel carrying the block format register.
interface dxt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] block_format;

    modport source (output valid, output block_format, input ready);
    modport sink   (input valid, input block_format, output ready);
endinterface

// ----- sv/dxt_blk_if.sv -----
// Input channel carrying one compressed 4x4 block.
interface dxt_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] color_part;
    logic [63:0] alpha_part;

    modport source (output valid, output color_part, output alpha_part, input ready);
    modport sink   (input valid, input color_part, input alpha_part, output ready);
endinterface

// ----- sv/dxt_row_if.sv -----
// Output channel carrying one decoded row of four ARGB pixels.
interface dxt_row_if;
    logic        valid;
    logic        ready;
    logic [1:0]  row_index;
    logic [31:0] pixel_a;
    logic [31:0] pixel_b;
    logic [31:0] pixel_c;
    logic [31:0] pixel_d;
    logic        final_row;

    modport source (output valid, output row_index, output pixel_a, output pixel_b,
                    output pixel_c, output pixel_d, output final_row, input ready);
    modport sink   (input valid, input row_index, input pixel_a, input pixel_b,
                    input pixel_c, input pixel_d, input final_row, output ready);
endinterface

// ----- sv/dxt_block_decoder.sv -----
// Top level: decodes one DXT1/3/5 block into four rows of ARGB pixels.
// Rows of a taken block pass from the held-block registers through the result register.
// One row per cycle while the output is ready, drained through the single result
// register; the next block is taken in the same cycle as the last row of the
// current one leaves the held block.
// Reset clears the valid flags and row counter and sets the format to DXT1.
module dxt_block_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dxt_cfg_if.sink   i_cfg,
    dxt_blk_if.sink   i_blk,
    dxt_row_if.source o_row
);

    dxt_pkg::t_fmt r_fmt;
    dxt_pkg::t_fmt n_fmt;
    logic          r_in_vld;
    logic [1:0]    r_row;
    logic [63:0]   r_color;
    logic [63:0]   r_alpha;
    logic          r_out_vld;
    logic [1:0]    r_out_row;
    logic [3:0][31:0] r_out_pix;
    logic [3:0][31:0] n_pix;

    dxt_pkg::t_pal pal;
    logic          out_load;
    logic          emit;
    logic          last;
    logic          blk_ready;
    logic          blk_take;

    // Palette of the held block.
    dxt_palette u_palette (
        .i_color_ends (r_color[31:0]),
        .i_alpha_ends (r_alpha[15:0]),
        .i_fmt        (r_fmt),
        .o_pal        (pal)
    );

    // Handshake control.
    assign out_load  = !r_out_vld || o_row.ready;
    assign emit      = r_in_vld && out_load;
    assign last      = (r_row == dxt_pkg::LAST_ROW);
    assign blk_ready = !r_in_vld || (emit && last);
    assign blk_take  = i_blk.valid && blk_ready;

    assign i_blk.ready = blk_ready;
    assign i_cfg.ready = 1'b1;

    // Format code 3 is treated as DXT5.
    always_comb begin
        if (i_cfg.block_format == dxt_pkg::FMT_DXT1) begin
            n_fmt = dxt_pkg::FMT_DXT1;
        end else if (i_cfg.block_format == dxt_pkg::FMT_DXT3) begin
            n_fmt = dxt_pkg::FMT_DXT3;
        end else begin
            n_fmt = dxt_pkg::FMT_DXT5;
        end
    end

    // Pixels of the current row.
    always_comb begin
        logic [1:0] ci;
        logic [3:0] nib;
        logic [2:0] ai;
        logic [7:0] a;
        for (int x = 0; x < 4; x++) begin
            ci  = r_color[6'(32 + 8 * r_row + 2 * x) +: 2];
            nib = r_alpha[6'(16 * r_row + 4 * x) +: 4];
            ai  = r_alpha[6'(16 + 12 * r_row + 3 * x) +: 3];
            case (r_fmt)
                dxt_pkg::FMT_DXT1: begin
                    a = (pal.three_color && ci == 2'd3) ? dxt_pkg::ALPHA_CLEAR
                                                        : dxt_pkg::ALPHA_OPAQUE;
                end
                dxt_pkg::FMT_DXT3: begin
                    a = {nib, nib};
                end
                default: begin
                    a = pal.alpha[ai];
                end
            endcase
            n_pix[x] = {a, pal.red[ci], pal.green[ci], pal.blue[ci]};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= dxt_pkg::FMT_DXT1;
            r_in_vld  <= 1'b0;
            r_row     <= 2'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_fmt <= n_fmt;
            end
            if (blk_take) begin
                r_in_vld <= 1'b1;
                r_row    <= 2'd0;
            end else if (emit) begin
                if (last) begin
                    r_in_vld <= 1'b0;
                end
                r_row <= r_row + 2'd1;
            end
            if (out_load) begin
                r_out_vld <= emit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (blk_take) begin
            r_color <= i_blk.color_part;
            r_alpha <= i_blk.alpha_part;
        end
        if (emit) begin
            r_out_row <= r_row;
            r_out_pix <= n_pix;
        end
    end

    assign o_row.valid     = r_out_vld;
    assign o_row.row_index = r_out_row;
    assign o_row.pixel_a   = r_out_pix[0];
    assign o_row.pixel_b   = r_out_pix[1];
    assign o_row.pixel_c   = r_out_pix[2];
    assign o_row.pixel_d   = r_out_pix[3];
    assign o_row.final_row = (r_out_row == dxt_pkg::LAST_ROW);

    // A taken block starts at row 0.
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_take |=> (r_in_vld && r_row == 2'd0))
        else $error("accepted block did not start at row 0");

    // No new block while the held one still has rows to send.
    a_no_early_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !(emit && last)) |-> !i_blk.ready)
        else $error("block accepted before the held block drained");

    // A row leaves the held block only into a free result register.
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !blk_take) |=> (r_out_vld && r_out_row == $past(r_row)))
        else $error("emitted row missing from the result register");

    // The held block advances one row per emitted row.
    a_row_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last && !blk_take) |=> (r_in_vld && r_row == $past(r_row) + 2'd1))
        else $error("row counter skipped");

endmodule

// ----- sv/dxt_palette.sv -----
// Builds the color palette and the interpolated alpha table of one block.
module dxt_palette (
    input  logic [31:0]   i_color_ends,
    input  logic [15:0]   i_alpha_ends,
    input  dxt_pkg::t_fmt i_fmt,
    output dxt_pkg::t_pal o_pal
);

    // Divide a sum of at most 765 by three: multiply by 683/2048.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        begin
            p = 21'(x) * 21'd683;
            return p[18:11];
        end
    endfunction

    // Divide a sum of at most 1788 by seven: multiply by 2341/16384.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        begin
            p = 23'(x) * 23'd2341;
            return p[21:14];
        end
    endfunction

    // Divide a sum of at most 1277 by five: multiply by 3277/16384.
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        begin
            p = 23'(x) * 23'd3277;
            return p[21:14];
        end
    endfunction

    logic [15:0] e0;
    logic [15:0] e1;
    logic [7:0]  r0, g0, b0, r1, g1, b1;
    logic [7:0]  a0, a1;
    logic        three;

    assign e0 = i_color_ends[15:0];
    assign e1 = i_color_ends[31:16];
    assign a0 = i_alpha_ends[7:0];
    assign a1 = i_alpha_ends[15:8];

    // Widen 565 endpoints to 888 by replicating the top bits.
    assign r0 = {e0[15:11], e0[15:13]};
    assign g0 = {e0[10:5],  e0[10:9]};
    assign b0 = {e0[4:0],   e0[4:2]};
    assign r1 = {e1[15:11], e1[15:13]};
    assign g1 = {e1[10:5],  e1[10:9]};
    assign b1 = {e1[4:0],   e1[4:2]};

    // Only DXT1 may switch to the three-color mode.
    assign three = (i_fmt == dxt_pkg::FMT_DXT1) && (e0 <= e1);

    // Color palette, then the alpha table: eight levels when a0 > a1,
    // else six levels plus 0 and 255.
    always_comb begin
        o_pal.three_color = three;
        o_pal.red[0]   = r0;
        o_pal.green[0] = g0;
        o_pal.blue[0]  = b0;
        o_pal.red[1]   = r1;
        o_pal.green[1] = g1;
        o_pal.blue[1]  = b1;
        if (three) begin
            o_pal.red[2]   = 8'((9'(r0) + 9'(r1)) >> 1);
            o_pal.green[2] = 8'((9'(g0) + 9'(g1)) >> 1);
            o_pal.blue[2]  = 8'((9'(b0) + 9'(b1)) >> 1);
            o_pal.red[3]   = 8'd0;
            o_pal.green[3] = 8'd0;
            o_pal.blue[3]  = 8'd0;
        end else begin
            o_pal.red[2]   = div3({1'b0, r0, 1'b0} + 10'(r1));
            o_pal.green[2] = div3({1'b0, g0, 1'b0} + 10'(g1));
            o_pal.blue[2]  = div3({1'b0, b0, 1'b0} + 10'(b1));
            o_pal.red[3]   = div3(10'(r0) + {1'b0, r1, 1'b0});
            o_pal.green[3] = div3(10'(g0) + {1'b0, g1, 1'b0});
            o_pal.blue[3]  = div3(10'(b0) + {1'b0, b1, 1'b0});
        end

        o_pal.alpha[0] = a0;
        o_pal.alpha[1] = a1;
        if (a0 > a1) begin
            for (int i = 0; i < 6; i++) begin
                o_pal.alpha[i + 2] = div7(11'((6 - i) * a0 + (1 + i) * a1 + 3));
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                o_pal.alpha[i + 2] = div5(11'((4 - i) * a0 + (1 + i) * a1 + 2));
            end
            o_pal.alpha[6] = dxt_pkg::ALPHA_CLEAR;
            o_pal.alpha[7] = dxt_pkg::ALPHA_OPAQUE;
        end
    end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the DXT block decoder: random and directed blocks in every format.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Format code 3 is not named in the package; the decoder treats it as DXT5.
    localparam logic [1:0] FMT_SPARE = 2'd3;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 150;
    localparam int TAIL_CYCLES = 12;
    localparam int PRINT_CAP   = 40;

    // One compressed block waiting to be sent.
    typedef struct packed {
        logic [63:0] color_part;
        logic [63:0] alpha_part;
    } t_blk_item;

    // One decoded row; pix[0] is column a.
    typedef struct packed {
        logic [1:0]       idx;
        logic [3:0][31:0] pix;
        logic             last;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;

    dxt_cfg_if cfg_ch();
    dxt_blk_if blk_ch();
    dxt_row_if row_ch();

    dxt_block_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_blk   (blk_ch),
        .o_row   (row_ch)
    );

    t_blk_item  blocks_waiting[$];
    t_row       rows_due[$];
    logic [1:0] fmt_now;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         send_gap;
    int         hold_left;
    int         hold_requests = 0;
    int         hold_served;
    bit         steady = 1'b0;

    // Clock: 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly back to back, sometimes a short pause, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch in %s at cycle %0d: got %h, expected %h",
                     what, cycle_count, got, want);
    endtask

    // Works out the four rows that one block decodes to and queues them.
    function automatic void predict_rows(logic [1:0] fmt, logic [63:0] cp, logic [63:0] ap);
        logic [1:0]  eff;
        logic [15:0] e0, e1;
        logic [4:0]  r5;
        logic [5:0]  g6;
        logic [4:0]  b5;
        int          red[4], grn[4], blu[4], calpha[4], atab[8];
        logic [7:0]  rowbyte;
        logic [1:0]  ci;
        logic [7:0]  a;
        logic [31:0] pix;
        t_row        rr;
        eff = (fmt == FMT_SPARE) ? dxt_pkg::FMT_DXT5 : fmt;
        e0 = cp[15:0];
        e1 = cp[31:16];

        // Endpoints widened from 565 to 888 by repeating the top bits.
        for (int k = 0; k < 2; k++) begin
            r5 = (k == 0) ? e0[15:11] : e1[15:11];
            g6 = (k == 0) ? e0[10:5]  : e1[10:5];
            b5 = (k == 0) ? e0[4:0]   : e1[4:0];
            red[k] = {r5, r5[4:2]};
            grn[k] = {g6, g6[5:4]};
            blu[k] = {b5, b5[4:2]};
        end
        for (int k = 0; k < 4; k++) calpha[k] = 255;

        // Four-color mode unless DXT1 with endpoint0 not above endpoint1.
        if (e0 > e1 || eff != dxt_pkg::FMT_DXT1) begin
            red[2] = (2 * red[0] + red[1]) / 3;
            grn[2] = (2 * grn[0] + grn[1]) / 3;
            blu[2] = (2 * blu[0] + blu[1]) / 3;
            red[3] = (red[0] + 2 * red[1]) / 3;
            grn[3] = (grn[0] + 2 * grn[1]) / 3;
            blu[3] = (blu[0] + 2 * blu[1]) / 3;
        end else begin
            red[2] = (red[0] + red[1]) / 2;
            grn[2] = (grn[0] + grn[1]) / 2;
            blu[2] = (blu[0] + blu[1]) / 2;
            red[3] = 0;
            grn[3] = 0;
            blu[3] = 0;
            calpha[3] = 0;
        end

        // Interpolated alpha table: eight levels, or six plus 0 and 255.
        atab[0] = ap[7:0];
        atab[1] = ap[15:8];
        if (atab[0] > atab[1]) begin
            for (int k = 0; k < 6; k++)
                atab[k + 2] = ((6 - k) * atab[0] + (1 + k) * atab[1] + 3) / 7;
        end else begin
            for (int k = 0; k < 4; k++)
                atab[k + 2] = ((4 - k) * atab[0] + (1 + k) * atab[1] + 2) / 5;
            atab[6] = 0;
            atab[7] = 255;
        end

        for (int y = 0; y < 4; y++) begin
            rowbyte = cp[32 + 8 * y +: 8];
            rr.idx  = 2'(y);
            rr.last = (y == 3);
            for (int x = 0; x < 4; x++) begin
                ci = rowbyte[2 * x +: 2];
                if (eff == dxt_pkg::FMT_DXT1)
                    a = 8'(calpha[ci]);
                else if (eff == dxt_pkg::FMT_DXT3)
                    a = 8'(ap[16 * y + 4 * x +: 4] * 17);
                else
                    a = 8'(atab[ap[16 + 3 * (4 * y + x) +: 3]]);
                pix[31:24] = a;
                pix[23:16] = 8'(red[ci]);
                pix[15:8]  = 8'(grn[ci]);
                pix[7:0]   = 8'(blu[ci]);
                rr.pix[x]  = pix;
            end
            rows_due.push_back(rr);
        end
    endfunction

    // Block driver: offers the queued blocks with random gaps between them.
    always @(posedge clk) begin : drive_blocks
        t_blk_item nxt;
        if (!rst_n) begin
            blk_ch.valid <= 1'b0;
            send_gap     <= 0;
        end else if (!blk_ch.valid || blk_ch.ready) begin
            if (send_gap != 0) begin
                blk_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (blocks_waiting.size() != 0) begin
                nxt = blocks_waiting.pop_front();
                blk_ch.valid      <= 1'b1;
                blk_ch.color_part <= nxt.color_part;
                blk_ch.alpha_part <= nxt.alpha_part;
                send_gap          <= steady ? 0 : pick_gap();
            end else begin
                blk_ch.valid <= 1'b0;
            end
        end
    end

    // Row receiver: random stalls, plus a long hold whenever one is requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            row_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_served  <= 0;
        end else if (hold_left != 0) begin
            row_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            row_ch.ready <= 1'b0;
            hold_left    <= LONG_HOLD;
            hold_served  <= hold_requests;
        end else if (steady || $urandom_range(0, 3) != 0) begin
            row_ch.ready <= 1'b1;
        end else begin
            row_ch.ready <= 1'b0;
            hold_left    <= pick_gap();
        end
    end

    // Monitor: tracks the format, predicts each taken block and checks each row.
    always @(posedge clk) begin : watch
        t_row got, want;
        if (!rst_n) begin
            fmt_now = dxt_pkg::FMT_DXT1;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                fmt_now = cfg_ch.block_format;
            if (blk_ch.valid && blk_ch.ready)
                predict_rows(fmt_now, blk_ch.color_part, blk_ch.alpha_part);
            if (row_ch.valid && row_ch.ready) begin
                got.idx  = row_ch.row_index;
                got.pix  = {row_ch.pixel_d, row_ch.pixel_c, row_ch.pixel_b, row_ch.pixel_a};
                got.last = row_ch.final_row;
                if (rows_due.size() == 0) begin
                    report_mismatch("row with nothing pending", got.pix[0], 0);
                end else begin
                    want = rows_due.pop_front();
                    if (got.idx !== want.idx)
                        report_mismatch("row_index", got.idx, want.idx);
                    for (int x = 0; x < 4; x++)
                        if (got.pix[x] !== want.pix[x])
                            report_mismatch($sformatf("pixel column %0d of row %0d", x, want.idx),
                                            got.pix[x], want.pix[x]);
                    if (got.last !== want.last)
                        report_mismatch("final_row", got.last, want.last);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Waits until no block is queued or in flight and every row has come back.
    task automatic wait_idle();
        do @(negedge clk);
        while (blocks_waiting.size() != 0 || blk_ch.valid || rows_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // Writes the format register once the decoder has drained.
    task automatic write_format(logic [1:0] fmt);
        wait_idle();
        @(posedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.block_format <= fmt;
        do @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic add_block(logic [63:0] cp, logic [63:0] ap);
        blocks_waiting.push_back('{color_part: cp, alpha_part: ap});
    endtask

    // Random blocks; now and then the endpoints are made equal.
    task automatic add_random(int count);
        logic [63:0] cp, ap;
        repeat (count) begin
            cp = {$urandom, $urandom};
            ap = {$urandom, $urandom};
            if ($urandom_range(0, 7) == 0) cp[31:16] = cp[15:0];
            if ($urandom_range(0, 7) == 0) ap[15:8] = ap[7:0];
            add_block(cp, ap);
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.block_format = dxt_pkg::FMT_DXT1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // DXT1: equal endpoints, transparent black, both modes, ignored alpha half.
        write_format(dxt_pkg::FMT_DXT1);
        add_block(64'h0, 64'h0);
        add_block('1, '1);
        add_block({32'hE4E4_E4E4, 16'h001F, 16'hF800}, 64'h0);
        add_block({32'hE4E4_E4E4, 16'hF800, 16'h001F}, '1);
        add_block({32'h1B1B_1B1B, 16'h07E0, 16'h07E1}, 64'h0123_4567_89AB_CDEF);
        add_block({32'h00FF_55AA, 16'hFFFF, 16'h0000}, 64'h0);
        add_random(20);

        // DXT3 with a sender that never pauses and a long receiver hold.
        write_format(dxt_pkg::FMT_DXT3);
        steady = 1'b1;
        add_block({32'hE4E4_E4E4, 16'h1234, 16'h1234}, '1);
        add_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, 64'h0);
        add_block({32'h1B1B_E4E4, 16'h8410, 16'h07E0}, 64'hFEDC_BA98_7654_3210);
        add_random(22);
        hold_requests++;
        wait_idle();
        steady = 1'b0;

        // DXT5: eight-level, six-level and equal alpha endpoints, every table index.
        write_format(dxt_pkg::FMT_DXT5);
        add_block({32'hE4E4_E4E4, 16'hF800, 16'h001F}, 64'hFAC6_88FA_C688_00FF);
        add_block({32'hE4E4_E4E4, 16'h001F, 16'hF800}, 64'hFAC6_88FA_C688_FF00);
        add_block({32'h1B1B_1B1B, 16'h0000, 16'hFFFF}, 64'hFAC6_88FA_C688_8080);
        add_block('1, '1);
        add_block({32'h39C6_93E4, 16'h07E0, 16'h07E0}, 64'hFAC6_88FA_C688_0102);
        add_random(25);

        // The spare format code behaves as DXT5.
        write_format(FMT_SPARE);
        add_block({32'hE4E4_E4E4, 16'hF800, 16'h001F}, 64'hFAC6_88FA_C688_00FF);
        add_block({32'hE4E4_E4E4, 16'h001F, 16'hF800}, 64'hFAC6_88FA_C688_FF00);
        add_random(15);

        write_format(dxt_pkg::FMT_DXT1);
        add_random(25);

        write_format(dxt_pkg::FMT_DXT5);
        steady = 1'b1;
        add_random(25);
        wait_idle();
        steady = 1'b0;

        write_format(dxt_pkg::FMT_DXT3);
        add_random(25);

        // Drain, then give any stray row time to show up.
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && rows_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- dxt_block_decoder.f -----
sv/dxt_pkg.sv
sv/dxt_cfg_if.sv
sv/dxt_blk_if.sv
sv/dxt_row_if.sv
sv/dxt_palette.sv
sv/dxt_block_decoder.sv
sim/tb.sv
